// ===== design/jtag_scan_sequencer_top_assert.svh =====
// Assertion macros shared by the JTAG scan sequencer checkers.
// Each macro expands to one labeled concurrent assertion on aclk, held off during reset.
`ifndef JTAG_SCAN_SEQUENCER_TOP_ASSERT_SVH
`define JTAG_SCAN_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication.
`define JSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define JSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/jss_pkg.sv =====
// Shared types and codes for the JTAG scan sequencer.
// No dependencies; used by jss_in_reg, jss_core and the top level.
package jss_pkg;

    localparam int SLOT_W = 6;

    typedef enum logic [2:0] {
        OP_RESET = 3'd0,
        OP_IR    = 3'd1,
        OP_DR16  = 3'd2,
        OP_DR20  = 3'd3,
        OP_DR32  = 3'd4
    } op_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_t;

    // One input transaction, unpacked from the stream.
    typedef struct packed {
        logic        command;
        logic [2:0]  operation;
        logic [31:0] shift_data;
        logic        tclk_level;
        logic        tdo_bit;
    } in_item_t;

    // One result transaction; last field (slot_valid) in the lowest bits.
    typedef struct packed {
        logic        request_rejected;
        logic [31:0] captured_word;
        logic        scan_done;
        logic        sample_tdo;
        logic        tdi_level;
        logic        tms_level;
        logic        slot_valid;
    } result_t;

endpackage

// ===== design/jss_in_reg.sv =====
// Input register stage of the JTAG scan sequencer.
// Depends on jss_pkg for the input item type.
module jss_in_reg
    import jss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        advance,
    output logic        item_valid,
    output in_item_t    item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register frees up in the same cycle its content moves on.
    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.command    <= s_tuser[0];
            item_reg.operation  <= s_tdata[2:0];
            item_reg.shift_data <= s_tdata[34:3];
            item_reg.tclk_level <= s_tdata[35];
            item_reg.tdo_bit    <= s_tdata[36];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/jss_core.sv =====
// Scan state and single-pass slot logic of the JTAG scan sequencer.
// Depends on jss_pkg for operation codes and the item and result types.
module jss_core
    import jss_pkg::*;
#(
    parameter int RESET_CLOCKS  = 6,
    parameter int MAX_SCAN_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     advance,
    input  in_item_t item,
    output result_t  result
);

    logic              busy_reg, busy_next;
    logic [2:0]        op_reg, op_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [31:0]       sh_reg, sh_next;
    logic [31:0]       cap_reg, cap_next;
    logic              tclk_reg, tclk_next;
    logic              pend_reg, pend_next;

    logic              is_start, start_ok, tick_ok, emit;
    logic [2:0]        emit_op;
    logic [SLOT_W-1:0] emit_k, pre, nbits;
    logic [31:0]       emit_sh, sh_after, cap_fold, word;
    logic              emit_tclk, tms, tdi, smp, msb_bit;
    logic [19:0]       rot20;

    function automatic logic [SLOT_W-1:0] scan_len(input logic [2:0] op);
        case (op)
            OP_IR:   scan_len = SLOT_W'(8);
            OP_DR16: scan_len = SLOT_W'(16);
            OP_DR20: scan_len = SLOT_W'(20);
            default: scan_len = SLOT_W'(MAX_SCAN_BITS);
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] pre_len(input logic [2:0] op);
        pre_len = (op == OP_IR) ? SLOT_W'(4) : SLOT_W'(3);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_count(input logic [2:0] op);
        if (op == OP_RESET) begin
            slot_count = SLOT_W'(RESET_CLOCKS + 1);
        end else begin
            slot_count = pre_len(op) + scan_len(op) + SLOT_W'(2);
        end
    endfunction

    assign is_start = (item.command == CMD_START);
    assign start_ok = is_start && !busy_reg && (item.operation <= OP_DR32);
    assign tick_ok  = !is_start && busy_reg;

    // A start emits its first slot at once; a tick emits while slots remain.
    assign emit = start_ok || (tick_ok && (idx_reg < slot_count(op_reg)));

    assign emit_op   = is_start ? item.operation : op_reg;
    assign emit_k    = is_start ? '0 : idx_reg;
    assign emit_sh   = is_start ? item.shift_data : sh_reg;
    assign emit_tclk = is_start ? item.tclk_level : tclk_reg;
    assign pre       = pre_len(emit_op);
    assign nbits     = scan_len(emit_op);
    assign cap_fold  = pend_reg ? {cap_reg[30:0], item.tdo_bit} : cap_reg;

    always_comb begin
        case (emit_op)
            OP_IR:   msb_bit = emit_sh[7];
            OP_DR16: msb_bit = emit_sh[15];
            OP_DR20: msb_bit = emit_sh[19];
            default: msb_bit = emit_sh[MAX_SCAN_BITS-1];
        endcase
    end

    always_comb begin
        tms      = 1'b0;
        tdi      = 1'b1;
        smp      = 1'b0;
        sh_after = emit_sh;
        if (emit_op == OP_RESET) begin
            tms = (emit_k < SLOT_W'(RESET_CLOCKS));
        end else if (emit_k == '0) begin
            tms = 1'b1;
            tdi = emit_tclk;
        end else if (emit_k < pre) begin
            tms = (emit_op == OP_IR) && (emit_k == SLOT_W'(1));
        end else if (emit_k < pre + nbits) begin
            tdi      = msb_bit;
            sh_after = {emit_sh[30:0], 1'b0};
            tms      = (emit_k == pre + nbits - SLOT_W'(1));
            smp      = 1'b1;
        end else if (emit_k == pre + nbits) begin
            tms = 1'b1;
        end else begin
            tdi = emit_tclk;
        end
    end

    // The 20-bit capture comes back rotated right by four within 20 bits.
    assign rot20 = cap_fold[23:4] + {cap_fold[3:0], 16'h0000};

    always_comb begin
        case (op_reg)
            OP_RESET: word = '0;
            OP_DR20:  word = {12'h000, rot20};
            default:  word = cap_fold;
        endcase
    end

    always_comb begin
        result = '0;
        if (emit) begin
            result.slot_valid = 1'b1;
            result.tms_level  = tms;
            result.tdi_level  = tdi;
            result.sample_tdo = smp;
        end else if (tick_ok) begin
            result.scan_done     = 1'b1;
            result.captured_word = word;
        end else begin
            result.request_rejected = 1'b1;
        end
    end

    always_comb begin
        busy_next = busy_reg;
        op_next   = op_reg;
        idx_next  = idx_reg;
        sh_next   = sh_reg;
        cap_next  = cap_reg;
        tclk_next = tclk_reg;
        pend_next = pend_reg;
        if (advance) begin
            if (start_ok) begin
                busy_next = 1'b1;
                op_next   = item.operation;
                cap_next  = '0;
                tclk_next = item.tclk_level;
            end else if (tick_ok) begin
                cap_next  = cap_fold;
                pend_next = 1'b0;
                if (!emit) begin
                    busy_next = 1'b0;
                end
            end
            if (emit) begin
                idx_next  = emit_k + SLOT_W'(1);
                sh_next   = sh_after;
                pend_next = smp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            op_reg   <= OP_RESET;
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            op_reg   <= op_next;
            idx_reg  <= idx_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg   <= sh_next;
        cap_reg  <= cap_next;
        tclk_reg <= tclk_next;
    end

endmodule

// ===== design/jtag_scan_sequencer_top.sv =====
// Top level of the JTAG scan sequencer: input stage, scan core and result register.
// Depends on jss_pkg, jss_in_reg and jss_core.
//
// The block is a JTAG TAP master driven one transaction at a time on the slave
// stream. A start transaction (s_tuser = 0) loads a request: TAP reset, 8-bit IR
// scan or a 16-, 20- or full-width DR scan, and answers with the first TAP clock
// slot. Each tick transaction (s_tuser = 1) returns the TDO seen in the previous
// slot and answers with the next slot; the tick after the last slot answers with
// m_tlast (scan_done) and the captured word, and the block is idle again. A start
// while a scan runs, a start with an unknown operation, or a tick while idle is
// answered with request_rejected and changes nothing.
// Every input transaction yields exactly one result transaction. A result passes
// through the input register and then the result register. With the receiver
// ready, one transaction per cycle flows through; the throughput is set by the
// combinational slot logic in jss_core. When the receiver stalls, the result
// register holds its transaction; s_tready drops at once if the input register
// is occupied, else after one more transaction.
// A synchronous active-low reset empties both registers and returns the scan
// state to idle.
module jtag_scan_sequencer_top
    import jss_pkg::*;
#(
    parameter int RESET_CLOCKS  = 6,
    parameter int MAX_SCAN_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], shift_data[34:3], tclk_level[35], tdo_bit[36], zero pad[39:37]
    input  logic [39:0] s_tdata,
    // command[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tms_level[0], tdi_level[1], sample_tdo[2], captured_word[34:3], zero pad[39:35]
    output logic [39:0] m_tdata,
    // slot_valid[0], request_rejected[1]
    output logic [1:0]  m_tuser,
    // High on the transaction that finishes a scan (scan_done).
    output logic        m_tlast
);

    logic     item_valid;
    logic     advance;
    in_item_t item;
    result_t  result;
    result_t  result_reg;
    logic     m_valid_reg, m_valid_next;

    // An item moves from the input register into the result register whenever
    // the result register is empty or being emptied in this cycle.
    assign advance = item_valid && (!m_valid_reg || m_tready);

    jss_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    jss_core #(
        .RESET_CLOCKS  (RESET_CLOCKS),
        .MAX_SCAN_BITS (MAX_SCAN_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    assign m_valid_next = advance || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, result_reg.captured_word, result_reg.sample_tdo,
                       result_reg.tdi_level, result_reg.tms_level};
    assign m_tuser  = {result_reg.request_rejected, result_reg.slot_valid};
    assign m_tlast  = result_reg.scan_done;

endmodule

// ===== design/jss_checker.sv =====
// Port-level checker for the JTAG scan sequencer, bound to the top level.
// Depends on jtag_scan_sequencer_top_assert.svh for the assertion macros.
`include "jtag_scan_sequencer_top_assert.svh"

module jss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result transaction keeps its content.
    `JSS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tlast, m_tuser, m_tdata}), "result changed while stalled")

    // Every result is exactly one of: a slot, a finished scan, a rejection.
    `JSS_ASSERT_NOW(a_kind, m_tvalid, $countones({m_tuser[0], m_tlast, m_tuser[1]}) == 1, "result kind not unique")

    // Results that drive no slot carry quiet slot fields.
    `JSS_ASSERT_NOW(a_quiet, m_tvalid && !m_tuser[0], m_tdata[2:0] == 3'b000, "slot fields set without a slot")

    // The captured word is shown only with scan_done.
    `JSS_ASSERT_NOW(a_word, m_tvalid && !m_tlast, m_tdata[34:3] == 32'h0, "captured word without scan_done")

endmodule

bind jtag_scan_sequencer_top jss_checker u_jss_checker (.*);
